// ===== src/blmst_pkg.sv =====
// Package for the bounded linear motion stepper: widths, register indexes,
// boundary modes, controller states and the command/status structs.
// No dependencies; every other file of the block imports it.
`default_nettype none

package blmst_pkg;

  // Position and velocity width (signed Q15.8 by default).
  localparam int unsigned POS_WIDTH = 24;
  localparam int unsigned FRAC_BITS = 8;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 3;

  // Stream packing: two positions in tdata, whole bytes.
  localparam int unsigned TDATA_W = ((2 * POS_WIDTH + 7) / 8) * 8;

  // Fold divider: quotient bits retired per cycle and derived sizes.
  localparam int unsigned DIV_RADIX_BITS = 2;
  localparam int unsigned DIV_STEPS = (POS_WIDTH + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int unsigned DIV_W = DIV_STEPS * DIV_RADIX_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Reset value of the upper bounds: 1.0 in Q15.8.
  localparam logic [POS_WIDTH-1:0] BOUND_HI_RST = POS_WIDTH'(1 << FRAC_BITS);

  // Extreme values of the signed position range.
  localparam logic [POS_WIDTH-1:0] POS_MOST_NEG = {1'b1, {(POS_WIDTH - 1){1'b0}}};
  localparam logic [POS_WIDTH-1:0] POS_MOST_POS = {1'b0, {(POS_WIDTH - 1){1'b1}}};

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_CLAMP  = 2'd1,
    MODE_BOUNCE = 2'd2,
    MODE_WRAP   = 2'd3
  } bmode_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MODE    = 3'd0,
    REG_MIN_X   = 3'd1,
    REG_MAX_X   = 3'd2,
    REG_MIN_Y   = 3'd3,
    REG_MAX_Y   = 3'd4,
    REG_VEL_X   = 3'd5,
    REG_VEL_Y   = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AXIS_X,
    ST_DIV_X,
    ST_AXIS_Y,
    ST_DIV_Y,
    ST_PUSH
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // take the input transfer and step the position
    logic axis_y;        // axis under work: 0 x, 1 y
    logic apply_simple;  // write the clamp result of the selected axis (clamp mode only)
    logic div_start;     // start a fold division for the selected axis
    logic apply_div;     // write the fold result of the selected axis
    logic push;          // move the position into the output register
  } blmst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;       // bounds of the current item are bad
    logic need_div;  // selected axis is out of range and must be folded
    logic div_done;  // fold division finished this cycle
    logic out_free;  // output register can take a result this cycle
  } blmst_sts_t;

endpackage

`default_nettype wire

// ===== src/blmst_div.sv =====
// Iterative restoring divider used for the bounce and wrap folds.
// Retires DIV_RADIX_BITS quotient bits per cycle; imports blmst_pkg.
`default_nettype none

module blmst_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [blmst_pkg::POS_WIDTH-1:0] dividend_i,
  input  wire logic [blmst_pkg::POS_WIDTH-1:0] divisor_i,
  output logic                                done_o,
  output logic                                q_lsb_o,
  output logic [blmst_pkg::POS_WIDTH-1:0]     rem_o
);
  import blmst_pkg::*;

  logic [DIV_W-1:0]     num_q, num_d;
  logic [POS_WIDTH-1:0] den_q;
  logic [POS_WIDTH-1:0] rem_q, rem_d;
  logic                 qb_q, qb_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic [POS_WIDTH:0]   trial;

  // Two dependent shift-subtract steps per cycle.
  always_comb begin
    rem_d = rem_q;
    qb_d  = qb_q;
    trial = '0;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      trial = {rem_d, num_q[DIV_W-1-i]};
      if (trial >= {1'b0, den_q}) begin
        trial = trial - {1'b0, den_q};
        qb_d  = 1'b1;
      end else begin
        qb_d  = 1'b0;
      end
      rem_d = trial[POS_WIDTH-1:0];
    end
    num_d = num_q << DIV_RADIX_BITS;
  end

  // Control: counter and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= DIV_CNT_W'(DIV_STEPS);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  // Operands and partial results.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= DIV_W'(dividend_i);
      den_q <= divisor_i;
      rem_q <= '0;
      qb_q  <= 1'b0;
    end else if (busy_q && (cnt_q != '0)) begin
      num_q <= num_d;
      rem_q <= rem_d;
      qb_q  <= qb_d;
    end
  end

  assign done_o  = busy_q && (cnt_q == '0);
  assign q_lsb_o = qb_q;
  assign rem_o   = rem_q;

endmodule

`default_nettype wire

// ===== src/blmst_dp.sv =====
// Datapath of the stepper: configuration registers, position and velocity
// state, clamp and fold logic, fold divider and output register.
// Imports blmst_pkg; instantiates blmst_div.
`default_nettype none

module blmst_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration writes.
  input  wire logic                             cfg_we_i,
  input  wire logic [blmst_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [blmst_pkg::POS_WIDTH-1:0]  cfg_data_i,
  // Input payload.
  input  wire logic [blmst_pkg::TDATA_W-1:0]    in_data_i,
  input  wire logic                             in_restart_i,
  input  wire logic                             in_last_i,
  // Output stream.
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [blmst_pkg::TDATA_W-1:0]         out_data_o,
  output logic                                  out_err_o,
  output logic                                  out_last_o,
  // Controller link.
  input  wire blmst_pkg::blmst_cmd_t            cmd_i,
  output blmst_pkg::blmst_sts_t                 sts_o
);
  import blmst_pkg::*;

  localparam int unsigned W = POS_WIDTH;

  // Configuration registers.
  bmode_e       mode_q;
  logic [W-1:0] min_x_q, max_x_q, min_y_q, max_y_q, svel_x_q, svel_y_q;

  // Working state.
  logic [W-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [W-1:0] vel_x_q, vel_x_d, vel_y_q, vel_y_d;
  logic         err_q, last_q;

  // Output register.
  logic         out_valid_q;
  logic [W-1:0] out_x_q, out_y_q;
  logic         out_err_q, out_last_q;

  // Axis selection and range checks.
  logic [W-1:0] p, v, lo, hi, r_u, clamp_res, fold_res, neg_v, div_n;
  logic [W:0]   d, r, abs_d, rem_e, hi_sub, lo_add;
  logic         d_neg, d_gt, use_hi, flip, err_now;
  logic         div_done, div_q_lsb;
  logic [W-1:0] div_rem;
  logic [W:0]   sum_x, sum_y;
  logic [W-1:0] sat_x, sat_y;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NONE;
      min_x_q  <= '0;
      max_x_q  <= BOUND_HI_RST;
      min_y_q  <= '0;
      max_y_q  <= BOUND_HI_RST;
      svel_x_q <= '0;
      svel_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_MODE:  mode_q   <= bmode_e'(cfg_data_i[1:0]);
        REG_MIN_X: min_x_q  <= cfg_data_i;
        REG_MAX_X: max_x_q  <= cfg_data_i;
        REG_MIN_Y: min_y_q  <= cfg_data_i;
        REG_MAX_Y: max_y_q  <= cfg_data_i;
        REG_VEL_X: svel_x_q <= cfg_data_i;
        REG_VEL_Y: svel_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Bad bounds: max not above min on either axis (signed compare).
  assign err_now = ($signed(max_x_q) <= $signed(min_x_q)) ||
                   ($signed(max_y_q) <= $signed(min_y_q));

  // Saturating frame step.
  assign sum_x = {pos_x_q[W-1], pos_x_q} + {vel_x_q[W-1], vel_x_q};
  assign sum_y = {pos_y_q[W-1], pos_y_q} + {vel_y_q[W-1], vel_y_q};
  assign sat_x = (sum_x[W] != sum_x[W-1]) ? (sum_x[W] ? POS_MOST_NEG : POS_MOST_POS)
                                          : sum_x[W-1:0];
  assign sat_y = (sum_y[W] != sum_y[W-1]) ? (sum_y[W] ? POS_MOST_NEG : POS_MOST_POS)
                                          : sum_y[W-1:0];

  // Selected axis and its offset from the bounds.
  assign p     = cmd_i.axis_y ? pos_y_q : pos_x_q;
  assign v     = cmd_i.axis_y ? vel_y_q : vel_x_q;
  assign lo    = cmd_i.axis_y ? min_y_q : min_x_q;
  assign hi    = cmd_i.axis_y ? max_y_q : max_x_q;
  assign d     = {p[W-1], p} - {lo[W-1], lo};
  assign r     = {hi[W-1], hi} - {lo[W-1], lo};
  assign r_u   = r[W-1:0];
  assign d_neg = d[W];
  assign d_gt  = !d_neg && (d[W-1:0] > r_u);
  assign abs_d = d_neg ? ((W + 1)'(0) - d) : d;
  assign div_n = abs_d[W-1:0] - W'(1);

  // Clamp result.
  assign clamp_res = d_neg ? lo : (d_gt ? hi : p);

  // Fold result from the divided offset: quotient parity and remainder.
  assign rem_e    = {1'b0, div_rem} + (W + 1)'(1);
  assign hi_sub   = {hi[W-1], hi} - rem_e;
  assign lo_add   = {lo[W-1], lo} + rem_e;
  assign use_hi   = (mode_q == MODE_WRAP) ? d_neg : div_q_lsb;
  assign flip     = (mode_q == MODE_BOUNCE) && (d_neg ? !div_q_lsb : div_q_lsb);
  assign fold_res = use_hi ? hi_sub[W-1:0] : lo_add[W-1:0];
  assign neg_v    = (v == POS_MOST_NEG) ? POS_MOST_POS : (W'(0) - v);

  blmst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_n),
    .divisor_i  (r_u),
    .done_o     (div_done),
    .q_lsb_o    (div_q_lsb),
    .rem_o      (div_rem)
  );

  // Next position and velocity.
  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    vel_x_d = vel_x_q;
    vel_y_d = vel_y_q;
    if (cmd_i.load) begin
      if (in_restart_i) begin
        pos_x_d = in_data_i[W-1:0];
        pos_y_d = in_data_i[2*W-1:W];
        vel_x_d = svel_x_q;
        vel_y_d = svel_y_q;
      end else if (!err_now) begin
        pos_x_d = sat_x;
        pos_y_d = sat_y;
      end
    end else if (cmd_i.apply_simple && (mode_q == MODE_CLAMP)) begin
      if (cmd_i.axis_y) begin
        pos_y_d = clamp_res;
      end else begin
        pos_x_d = clamp_res;
      end
    end else if (cmd_i.apply_div) begin
      if (cmd_i.axis_y) begin
        pos_y_d = fold_res;
        if (flip) begin
          vel_y_d = neg_v;
        end
      end else begin
        pos_x_d = fold_res;
        if (flip) begin
          vel_x_d = neg_v;
        end
      end
    end
  end

  // Working state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      vel_x_q <= '0;
      vel_y_q <= '0;
      err_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      vel_x_q <= vel_x_d;
      vel_y_q <= vel_y_d;
      if (cmd_i.load) begin
        err_q  <= err_now;
        last_q <= in_last_i;
      end
    end
  end

  // Output register: loads on push, empties on a downstream transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_x_q    <= pos_x_q;
      out_y_q    <= pos_y_q;
      out_err_q  <= err_q;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = TDATA_W'({out_y_q, out_x_q});
  assign out_err_o   = out_err_q;
  assign out_last_o  = out_last_q;

  // Status to the controller.
  assign sts_o.err      = err_q;
  assign sts_o.need_div = (d_neg || d_gt) &&
                          ((mode_q == MODE_BOUNCE) || (mode_q == MODE_WRAP));
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== src/blmst_ctrl.sv =====
// Controller state machine of the stepper: sequences input transfer,
// per-axis bound handling, fold divisions and the output push.
// Imports blmst_pkg.
`default_nettype none

module blmst_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire blmst_pkg::blmst_sts_t sts_i,
  output blmst_pkg::blmst_cmd_t      cmd_o
);
  import blmst_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_AXIS_X;
        end
      end
      ST_AXIS_X: begin
        if (sts_i.err) begin
          state_d = ST_PUSH;
        end else if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV_X;
        end else begin
          cmd_o.apply_simple = 1'b1;
          state_d            = ST_AXIS_Y;
        end
      end
      ST_DIV_X: begin
        if (sts_i.div_done) begin
          cmd_o.apply_div = 1'b1;
          state_d         = ST_AXIS_Y;
        end
      end
      ST_AXIS_Y: begin
        cmd_o.axis_y = 1'b1;
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV_Y;
        end else begin
          cmd_o.apply_simple = 1'b1;
          state_d            = ST_PUSH;
        end
      end
      ST_DIV_Y: begin
        cmd_o.axis_y = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.apply_div = 1'b1;
          state_d         = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/bounded_linear_motion_stepper_core.sv =====
// Top level of the bounded linear motion stepper: stream ports, config port,
// controller and datapath. Imports blmst_pkg; instantiates blmst_ctrl, blmst_dp.
//
// Usage:
// - Slave stream: one transfer per frame tick. tuser is the restart flag,
//   tlast marks the last frame, tdata holds start_x then start_y (used on
//   restart only). A restart loads the start point and start velocities;
//   any other tick adds the velocity to the position with saturation if the bounds are good.
// - Master stream: one transfer per input. tdata holds pos_x then pos_y,
//   tuser is the bounds error flag, tlast copies the input tlast.
// - Config port: cfg_addr_i selects mode, min_x, max_x, min_y, max_y,
//   start_vel_x, start_vel_y; cfg_ready_o is always high. Write only idle.
// - After the input transfer, bounds are applied to x and then y (not when they
//   are bad) and the result is pushed; the next input is taken only then. Each
//   axis that bounce or wrap has to fold adds a division (shared divider, two bits per cycle).
// - A finished result waits in the output register while the next frame is
//   worked on; under a receiver stall work stops when a second one is ready.
// - Reset clears position and velocity, loads the register reset values and
//   leaves the block ready in the first cycle after it.
`default_nettype none

module bounded_linear_motion_stepper_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input stream.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [blmst_pkg::TDATA_W-1:0]    s_axis_tdata,  // start_x, start_y
  input  wire logic                             s_axis_tuser,  // restart
  input  wire logic                             s_axis_tlast,  // last_frame
  // Output stream.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [blmst_pkg::TDATA_W-1:0]         m_axis_tdata,  // pos_x_out, pos_y_out
  output logic                                  m_axis_tuser,  // bounds_error
  output logic                                  m_axis_tlast,  // last
  // Configuration write channel.
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [blmst_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [blmst_pkg::POS_WIDTH-1:0]  cfg_data_i
);
  import blmst_pkg::*;

  blmst_cmd_t cmd;
  blmst_sts_t sts;

  assign cfg_ready_o = 1'b1;

  blmst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  blmst_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_axis_tdata),
    .in_restart_i (s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_err_o    (m_axis_tuser),
    .out_last_o   (m_axis_tlast),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  // One frame at a time: an input transfer is never followed by another at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // A finished fold is always consumed by the controller.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_done |-> cmd.apply_div)
    else $error("fold result dropped");

  // A push always leaves a valid result on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |=> m_axis_tvalid)
    else $error("pushed result not presented");

endmodule

`default_nettype wire
